### rtl/fsic_pkg.sv
// shared types and constants for the fir self-interference canceller
// no dependencies; imported by fsic_cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package fsic_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int TAP_BITS     = 16;
    localparam int TAP_FRAC     = 12;
    localparam int TAP_IDX_W    = 5;
    localparam int PROD_W       = SAMPLE_BITS + TAP_BITS;
    localparam int MAX_TAPS_DEF = 32;
    localparam int CFG_W        = 5;
    localparam int HALF_TAPS_RST = 16;

    localparam logic [1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic                          sample;
        logic                          load;
        logic [TAP_IDX_W-1:0]          tap_index;
        logic signed [TAP_BITS-1:0]    tap_value;
        logic signed [SAMPLE_BITS-1:0] tx_sample;
        logic signed [SAMPLE_BITS-1:0] rx_sample;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/fir_self_interference_canceller_top.sv
// top level of the fir self-interference canceller: command decode, cell row,
// adder tree, rounding, saturation and output skid; depends on fsic_pkg,
// fsic_cell and fsic_adder_tree
//
// usage
//   s_ channel: one transaction per command. s_tuser is the action (sample pair,
//   load one tap, restart window). a sample pair shifts the transmit window and
//   the receive delay line; once 2k sample pairs have arrived since the last
//   restart, each one yields one cleaned sample on the m_ channel.
//   load and restart transactions yield nothing. cfg_wen writes half_taps (k)
//   and also empties the window; write it only while the block is idle.
//   throughput: one transaction per cycle while the skid entry is empty, set by
//   one multiplier per cell and a fully pipelined adder tree.
//   pipeline: product register loads on the accepting edge, then one register
//   per tree level, rounding register, output register.
//   reset: taps are zero, k is 16 (clamped to MAX_TAPS/2), the window is empty.
//   stall: a one-entry skid behind the output register catches the item in
//   flight; while it is occupied s_tready is low and the whole pipeline holds.
`timescale 1ns / 1ps
`default_nettype none

module fir_self_interference_canceller_top #(
    parameter int MAX_TAPS = fsic_pkg::MAX_TAPS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration: half_taps
    input  wire         cfg_wen,
    input  wire [4:0]   cfg_wdata,
    // input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    // tx_sample [15:0], rx_sample [31:16], tap_index [36:32], tap_value [52:37]
    input  wire [55:0]  s_tdata,
    // action [1:0]
    input  wire [1:0]   s_tuser,
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    // cleaned_sample [15:0]
    output logic [15:0] m_tdata,
    // clipped [0]
    output logic        m_tuser
);
    import fsic_pkg::*;

    localparam int TAPS_W   = $clog2(MAX_TAPS + 2);
    localparam int HALF_MAX = MAX_TAPS / 2;
    localparam int ACC_W    = PROD_W + $clog2(MAX_TAPS);
    localparam int RND_W    = ACC_W + 1 - TAP_FRAC;
    localparam int DIFF_W   = RND_W + 1;
    localparam int RST_K    = (HALF_TAPS_RST < HALF_MAX) ? HALF_TAPS_RST : HALF_MAX;

    localparam logic [TAPS_W-1:0]       TAPS_RST   = TAPS_W'(2 * RST_K);
    localparam logic [TAPS_W-1:0]       TAPS_MIN   = TAPS_W'(2);
    localparam logic [TAPS_W-1:0]       TAPS_MAX   = TAPS_W'(2 * HALF_MAX);
    localparam logic [ACC_W:0]          ROUND_BIAS = (ACC_W + 1)'(1 << (TAP_FRAC - 1));
    localparam logic signed [DIFF_W-1:0] SAT_HI    = DIFF_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [DIFF_W-1:0] SAT_LO    = DIFF_W'(-(1 << (SAMPLE_BITS - 1)));

    // field unpack
    logic [1:0]                    in_action;
    logic signed [SAMPLE_BITS-1:0] in_tx;
    logic signed [SAMPLE_BITS-1:0] in_rx;
    logic [TAP_IDX_W-1:0]          in_tap_index;
    logic signed [TAP_BITS-1:0]    in_tap_value;

    assign in_action    = s_tuser;
    assign in_tx        = s_tdata[15:0];
    assign in_rx        = s_tdata[31:16];
    assign in_tap_index = s_tdata[36:32];
    assign in_tap_value = s_tdata[52:37];

    // pipeline advance: everything holds while the skid entry is occupied
    logic en;
    logic s_xfer;
    logic do_sample;
    logic do_load;
    logic do_restart;

    logic skid_valid_reg;

    assign en         = !skid_valid_reg;
    assign s_tready   = en;
    assign s_xfer     = s_tvalid && s_tready;
    assign do_sample  = s_xfer && (in_action == ACT_SAMPLE);
    assign do_load    = s_xfer && (in_action == ACT_LOAD);
    assign do_restart = s_xfer && (in_action == ACT_RESTART);

    // filter length and window fill
    logic [TAPS_W-1:0] taps_reg;
    logic [TAPS_W-1:0] cfg_taps;
    logic [TAPS_W-1:0] fill_reg;
    logic              window_full;

    // k of zero acts as one, k above MAX_TAPS/2 acts as MAX_TAPS/2
    always_comb begin
        if (cfg_wdata == '0) begin
            cfg_taps = TAPS_MIN;
        end else if (32'(cfg_wdata) > 32'(HALF_MAX)) begin
            cfg_taps = TAPS_MAX;
        end else begin
            cfg_taps = TAPS_W'({cfg_wdata, 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg <= TAPS_RST;
        end else if (cfg_wen) begin
            taps_reg <= cfg_taps;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cfg_wen || do_restart) begin
            fill_reg <= '0;
        end else if (do_sample && (fill_reg < taps_reg)) begin
            fill_reg <= fill_reg + TAPS_W'(1);
        end
    end

    // full once this sample is counted
    assign window_full = (fill_reg >= taps_reg - TAPS_W'(1));

    // cell row
    cell_ctrl_t ctrl;

    assign ctrl.sample    = do_sample;
    assign ctrl.load      = do_load;
    assign ctrl.tap_index = in_tap_index;
    assign ctrl.tap_value = in_tap_value;
    assign ctrl.tx_sample = in_tx;
    assign ctrl.rx_sample = in_rx;

    logic signed [SAMPLE_BITS-1:0] tx_chain [0:MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] rx_chain [0:MAX_TAPS];
    logic signed [PROD_W-1:0]      prod     [MAX_TAPS];

    assign tx_chain[MAX_TAPS] = '0;
    assign rx_chain[MAX_TAPS] = '0;

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        fsic_cell #(
            .MAX_TAPS (MAX_TAPS),
            .CELL_IDX (j)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .taps     (taps_reg),
            .tx_in    (tx_chain[j + 1]),
            .rx_in    (rx_chain[j + 1]),
            .tx_out   (tx_chain[j]),
            .rx_out   (rx_chain[j]),
            .prod_out (prod[j])
        );
    end

    // stage alongside the product registers: receive sample leaving the delay line
    logic                          s0_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s0_rx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= do_sample && window_full;
        end
    end

    // cell 0 still holds the receive sample from 2k-1 pairs back
    always_ff @(posedge aclk) begin
        if (do_sample) begin
            s0_rx_reg <= rx_chain[0];
        end
    end

    // sum of products
    logic                     tree_valid;
    logic [SAMPLE_BITS-1:0]   tree_rx;
    logic signed [ACC_W-1:0]  tree_sum;

    fsic_adder_tree #(
        .N      (MAX_TAPS),
        .IN_W   (PROD_W),
        .SIDE_W (SAMPLE_BITS)
    ) u_tree (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_side   (s0_rx_reg),
        .in_terms  (prod),
        .out_valid (tree_valid),
        .out_side  (tree_rx),
        .out_sum   (tree_sum)
    );

    // round half up to q1.15: floor((sum + 2^11) / 2^12)
    logic [ACC_W:0]                biased;
    logic signed [RND_W-1:0]       rnd_next;
    logic                          f1_valid_reg;
    logic signed [RND_W-1:0]       rnd_reg;
    logic signed [SAMPLE_BITS-1:0] f1_rx_reg;

    assign biased   = (ACC_W + 1)'(tree_sum) + ROUND_BIAS;
    assign rnd_next = $signed(biased[ACC_W:TAP_FRAC]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= tree_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rnd_reg   <= rnd_next;
            f1_rx_reg <= $signed(tree_rx);
        end
    end

    // subtract and saturate
    logic signed [DIFF_W-1:0]      diff;
    logic [SAMPLE_BITS-1:0]        res_data;
    logic                          res_clip;

    assign diff = DIFF_W'(f1_rx_reg) - DIFF_W'(rnd_reg);

    always_comb begin
        if (diff > SAT_HI) begin
            res_data = SAT_HI[SAMPLE_BITS-1:0];
            res_clip = 1'b1;
        end else if (diff < SAT_LO) begin
            res_data = SAT_LO[SAMPLE_BITS-1:0];
            res_clip = 1'b1;
        end else begin
            res_data = diff[SAMPLE_BITS-1:0];
            res_clip = 1'b0;
        end
    end

    // output register with one-entry skid
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;
    logic                   out_clip_reg;
    logic [SAMPLE_BITS-1:0] skid_data_reg;
    logic                   skid_clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (f1_valid_reg) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
                out_clip_reg <= skid_clip_reg;
            end
        end else if (f1_valid_reg) begin
            if (out_valid_reg && !m_tready) begin
                skid_data_reg <= res_data;
                skid_clip_reg <= res_clip;
            end else begin
                out_data_reg <= res_data;
                out_clip_reg <= res_clip;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_clip_reg;

endmodule

`default_nettype wire

### rtl/fsic_cell.sv
// one filter cell: tap register, transmit and receive window slots, product register
// depends on fsic_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsic_cell #(
    parameter int MAX_TAPS = fsic_pkg::MAX_TAPS_DEF,
    parameter int CELL_IDX = 0,
    localparam int TAPS_W  = $clog2(MAX_TAPS + 2)
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  fsic_pkg::cell_ctrl_t                   ctrl,
    input  wire [TAPS_W-1:0]                       taps,
    input  wire signed [fsic_pkg::SAMPLE_BITS-1:0] tx_in,
    input  wire signed [fsic_pkg::SAMPLE_BITS-1:0] rx_in,
    output logic signed [fsic_pkg::SAMPLE_BITS-1:0] tx_out,
    output logic signed [fsic_pkg::SAMPLE_BITS-1:0] rx_out,
    output logic signed [fsic_pkg::PROD_W-1:0]      prod_out
);
    import fsic_pkg::*;

    localparam logic [TAPS_W-1:0] SELF_POS = TAPS_W'(CELL_IDX);
    localparam logic [TAPS_W-1:0] TX_ENTRY = TAPS_W'(CELL_IDX + 1);
    localparam logic [TAPS_W-1:0] RX_ENTRY = TAPS_W'(CELL_IDX + 2);

    logic signed [TAP_BITS-1:0]    tap_reg;
    logic signed [SAMPLE_BITS-1:0] tx_reg;
    logic signed [SAMPLE_BITS-1:0] rx_reg;
    logic signed [PROD_W-1:0]      prod_reg;

    logic signed [SAMPLE_BITS-1:0] tx_next;
    logic signed [SAMPLE_BITS-1:0] rx_next;
    logic signed [PROD_W-1:0]      prod_full;
    logic signed [PROD_W-1:0]      prod_next;
    logic                          active;
    logic                          tap_hit;

    // tx enters at the active window's top, rx one cell lower; both walk to cell 0
    assign tx_next   = (taps == TX_ENTRY) ? ctrl.tx_sample : tx_in;
    assign rx_next   = (taps == RX_ENTRY) ? ctrl.rx_sample : rx_in;
    assign active    = SELF_POS < taps;
    assign prod_full = tap_reg * tx_next;
    assign prod_next = active ? prod_full : '0;
    assign tap_hit   = ctrl.load && (32'(ctrl.tap_index) == 32'(CELL_IDX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg <= '0;
        end else if (tap_hit) begin
            tap_reg <= ctrl.tap_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sample) begin
            tx_reg   <= tx_next;
            rx_reg   <= rx_next;
            prod_reg <= prod_next;
        end
    end

    assign tx_out   = tx_reg;
    assign rx_out   = rx_reg;
    assign prod_out = prod_reg;

endmodule

`default_nettype wire

### rtl/fsic_adder_tree.sv
// registered binary adder tree over cell products, one level per enabled cycle
// carries the valid flag and a side word alongside; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module fsic_adder_tree #(
    parameter int N      = 32,
    parameter int IN_W   = 32,
    parameter int SIDE_W = 16,
    localparam int LEVELS = $clog2(N),
    localparam int OUT_W  = IN_W + LEVELS
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     en,
    input  wire                     in_valid,
    input  wire [SIDE_W-1:0]        in_side,
    input  wire signed [IN_W-1:0]   in_terms [N],
    output logic                    out_valid,
    output logic [SIDE_W-1:0]       out_side,
    output logic signed [OUT_W-1:0] out_sum
);

    localparam int LEAVES = 1 << LEVELS;

    logic signed [OUT_W-1:0] leaf [LEAVES];
    logic signed [OUT_W-1:0] node [1:LEAVES-1];
    logic                    valid_pipe [LEVELS];
    logic [SIDE_W-1:0]       side_pipe  [LEVELS];

    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < N) begin : g_used
            assign leaf[i] = OUT_W'(in_terms[i]);
        end else begin : g_pad
            assign leaf[i] = '0;
        end
    end

    // heap order: node n sums children 2n and 2n+1
    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        if (2 * n >= LEAVES) begin : g_bottom
            always_ff @(posedge aclk) begin
                if (en) begin
                    node[n] <= leaf[2 * n - LEAVES] + leaf[2 * n + 1 - LEAVES];
                end
            end
        end else begin : g_inner
            always_ff @(posedge aclk) begin
                if (en) begin
                    node[n] <= node[2 * n] + node[2 * n + 1];
                end
            end
        end
    end

    for (genvar s = 0; s < LEVELS; s++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_pipe[s] <= 1'b0;
            end else if (en) begin
                valid_pipe[s] <= (s == 0) ? in_valid : valid_pipe[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_pipe[s] <= (s == 0) ? in_side : side_pipe[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign out_valid = valid_pipe[LEVELS-1];
    assign out_side  = side_pipe[LEVELS-1];
    assign out_sum   = node[1];

endmodule

`default_nettype wire
